@@ hdl/hsq_pkg.sv @@
// Shared types and constants of the hysteresis step quantizer.
package hsq_pkg;

	localparam int SampleW   = 32;
	localparam int StepW     = 16;
	localparam int TagW      = 8;
	localparam int CfgIdxW   = 2;
	localparam int ThrW      = 34;
	localparam int DivW      = 34;
	localparam int DivCntW   = $clog2(DivW + 1);
	localparam int MaxEvents = 63;
	localparam int EvCntW    = $clog2(MaxEvents + 1);
	localparam int MidScaleW = 17;
	localparam int MulAW     = SampleW + 1;
	localparam int MulBW     = MidScaleW + 1;
	localparam int MulPW     = MulAW + MulBW;
	localparam int DistShift = 7;
	localparam int DistW     = 8;
	localparam int DistSatLo = DistShift + DistW;

	localparam logic [StepW-1:0]   StepReset   = 16'd256;
	localparam logic [StepW-1:0]   HystReset   = 16'd0;
	localparam logic [TagW-1:0]    TagReset    = 8'd0;
	localparam logic [DivW-1:0]    MidNumer    = 34'h10000;
	localparam logic [DistW-1:0]   DistMax     = 8'd255;
	localparam logic [EvCntW-1:0]  MaxEvCnt    = EvCntW'(MaxEvents);

	localparam logic [CfgIdxW-1:0] CfgStep = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgHyst = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgTag  = 2'd2;

	localparam logic OpSample = 1'b0;
	localparam logic OpStop   = 1'b1;

	localparam logic KindEvent   = 1'b0;
	localparam logic KindSummary = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_LV,
		ST_DIV_MS,
		ST_DIST,
		ST_CMP,
		ST_DIV_N,
		ST_MOVE,
		ST_EVENT,
		ST_REM_MUL,
		ST_REM,
		ST_SUM
	} state_t;

endpackage

@@ hdl/hysteresis_step_quantizer.sv @@
// Hysteresis step quantizer: sequencer around one shared divider and one multiplier.
//
// Takes one input word at a time and is stalled while it works. The first sample
// after reset or stop runs two 34-step radix-2 divisions (level and mid-scale) on
// the shared restoring divider and gives no result. A later sample that stays
// between the thresholds gives one summary word; a sample that crosses a threshold
// adds one 34-step division for the move count, a state to move the thresholds,
// and one level-change word per level step, at most 63 of them, before its summary.
// A finished word sits in an output register, so the next input word is taken
// while it waits. A step size of zero acts as one.
module hysteresis_step_quantizer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hsq_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [hsq_pkg::StepW-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               op,
	input  logic signed [hsq_pkg::SampleW-1:0] sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               kind,
	output logic signed [hsq_pkg::SampleW-1:0] level,
	output logic signed [hsq_pkg::SampleW-1:0] remainder,
	output logic [hsq_pkg::DistW-1:0]          mid_distance,
	output logic                               overflow,
	output logic [hsq_pkg::TagW-1:0]           event_tag,
	output logic                               last
);

	hsq_pkg::state_t state_q, state_d;

	logic [hsq_pkg::StepW-1:0]   step_q, hyst_q;
	logic [hsq_pkg::TagW-1:0]    tag_q;
	logic                        started_q;
	logic [hsq_pkg::SampleW-1:0] remainder_q;
	logic [hsq_pkg::DivCntW-1:0] div_cnt_q;
	logic [hsq_pkg::EvCntW-1:0]  ev_cnt_q;
	logic                        out_valid_q;

	logic [hsq_pkg::SampleW-1:0]   sample_q;
	logic [hsq_pkg::SampleW-1:0]   level_q;
	logic signed [hsq_pkg::ThrW-1:0] up_thr_q, down_thr_q;
	logic [hsq_pkg::MidScaleW-1:0] mid_scale_q;
	logic [hsq_pkg::DistW-1:0]     mid_q;
	logic [hsq_pkg::SampleW-1:0]   d_q;
	logic [hsq_pkg::MulPW-1:0]     mul_q;
	logic                          dir_up_q;
	logic                          ovf_q;
	logic [hsq_pkg::EvCntW-1:0]    ev_total_q;
	logic [hsq_pkg::SampleW-1:0]   ev_level_q;
	logic [hsq_pkg::DivW-1:0]      dvd_q;
	logic [hsq_pkg::ThrW-1:0]      nst_q;
	logic [hsq_pkg::StepW-1:0]     div_rem_q;
	logic [hsq_pkg::DivW-1:0]      div_quo_q;

	logic                          out_kind_q, out_ovf_q, out_last_q;
	logic [hsq_pkg::SampleW-1:0]   out_level_q, out_rem_q;
	logic [hsq_pkg::DistW-1:0]     out_mid_q;

	logic                          in_accept, out_free, out_load_ev, out_load_sum;
	logic [hsq_pkg::StepW-1:0]     st;
	logic signed [hsq_pkg::ThrW-1:0] st_x, hy_x, sample_x, abs_x, lvst, diff, dividend;
	logic                          gt, lt;
	logic signed [hsq_pkg::SampleW:0] rem_x, dd;
	logic [hsq_pkg::SampleW:0]     d_abs;
	logic [hsq_pkg::StepW+1:0]     div_trial;
	logic                          div_ge, div_done;
	logic [hsq_pkg::StepW-1:0]     div_rem_nx;
	logic [hsq_pkg::DivW-1:0]      div_quo_nx;
	logic signed [hsq_pkg::MulAW-1:0] mul_a;
	logic signed [hsq_pkg::MulBW-1:0] mul_b;
	logic signed [hsq_pkg::MulPW-1:0] mul_p;
	logic [hsq_pkg::DistW-1:0]     dist_sat;
	logic [hsq_pkg::SampleW-1:0]   ev_lv_nx, lv_start;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign st   = (step_q == '0) ? hsq_pkg::StepW'(1) : step_q;
	assign st_x = {{(hsq_pkg::ThrW-hsq_pkg::StepW){1'b0}}, st};
	assign hy_x = {{(hsq_pkg::ThrW-hsq_pkg::StepW){1'b0}}, hyst_q};
	assign sample_x = {{(hsq_pkg::ThrW-hsq_pkg::SampleW){sample_q[hsq_pkg::SampleW-1]}}, sample_q};
	assign abs_x = {{(hsq_pkg::ThrW-hsq_pkg::SampleW){sample[hsq_pkg::SampleW-1]}}, sample};

	// distance from mid-step uses the remainder left by the previous sample
	assign rem_x = {remainder_q[hsq_pkg::SampleW-1], remainder_q};
	assign dd    = rem_x - {{(hsq_pkg::SampleW+2-hsq_pkg::StepW){1'b0}}, st[hsq_pkg::StepW-1:1]};
	assign d_abs = dd[hsq_pkg::SampleW] ? -dd : dd;

	// start: level*step = sample minus the signed remainder of the truncating division
	assign lvst = sample_q[hsq_pkg::SampleW-1]
		? sample_x + {{(hsq_pkg::ThrW-hsq_pkg::StepW){1'b0}}, div_rem_q}
		: sample_x - {{(hsq_pkg::ThrW-hsq_pkg::StepW){1'b0}}, div_rem_q};
	assign lv_start = sample_q[hsq_pkg::SampleW-1] ? -div_quo_q[hsq_pkg::SampleW-1:0]
		: div_quo_q[hsq_pkg::SampleW-1:0];

	assign gt       = sample_x > up_thr_q;
	assign lt       = sample_x < down_thr_q;
	assign diff     = gt ? sample_x - up_thr_q : down_thr_q - sample_x;
	assign dividend = diff + st_x - hsq_pkg::ThrW'(1);

	// one restoring division step per cycle
	assign div_trial  = {1'b0, div_rem_q, div_quo_q[hsq_pkg::DivW-1]} - {2'b00, st};
	assign div_ge     = !div_trial[hsq_pkg::StepW+1];
	assign div_rem_nx = div_ge ? div_trial[hsq_pkg::StepW-1:0]
		: {div_rem_q[hsq_pkg::StepW-2:0], div_quo_q[hsq_pkg::DivW-1]};
	assign div_quo_nx = {div_quo_q[hsq_pkg::DivW-2:0], div_ge};
	assign div_done   = div_cnt_q == hsq_pkg::DivCntW'(hsq_pkg::DivW);

	// shared multiplier: distance product, then level times step
	always_comb begin
		if (state_q == hsq_pkg::ST_DIST) begin
			mul_a = {1'b0, d_q};
			mul_b = {1'b0, mid_scale_q};
		end else begin
			mul_a = {level_q[hsq_pkg::SampleW-1], level_q};
			mul_b = {{(hsq_pkg::MulBW-hsq_pkg::StepW){1'b0}}, st};
		end
	end
	assign mul_p = mul_a * mul_b;

	assign dist_sat = (|mul_q[hsq_pkg::MulPW-1:hsq_pkg::DistSatLo]) ? hsq_pkg::DistMax
		: mul_q[hsq_pkg::DistSatLo-1:hsq_pkg::DistShift];

	assign ev_lv_nx = dir_up_q ? ev_level_q + hsq_pkg::SampleW'(1)
		: ev_level_q - hsq_pkg::SampleW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		out_load_ev  = 1'b0;
		out_load_sum = 1'b0;
		case (state_q)
			hsq_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && op == hsq_pkg::OpSample) begin
					state_d = started_q ? hsq_pkg::ST_DIST : hsq_pkg::ST_DIV_LV;
				end
			end
			hsq_pkg::ST_DIV_LV: begin
				if (div_done) state_d = hsq_pkg::ST_DIV_MS;
			end
			hsq_pkg::ST_DIV_MS: begin
				if (div_done) state_d = hsq_pkg::ST_IDLE;
			end
			hsq_pkg::ST_DIST: state_d = hsq_pkg::ST_CMP;
			hsq_pkg::ST_CMP: begin
				state_d = (gt || lt) ? hsq_pkg::ST_DIV_N : hsq_pkg::ST_REM_MUL;
			end
			hsq_pkg::ST_DIV_N: begin
				if (div_done) state_d = hsq_pkg::ST_MOVE;
			end
			hsq_pkg::ST_MOVE: state_d = hsq_pkg::ST_EVENT;
			hsq_pkg::ST_EVENT: begin
				if (out_free) begin
					out_load_ev = 1'b1;
					if (ev_cnt_q + hsq_pkg::EvCntW'(1) == ev_total_q) begin
						state_d = hsq_pkg::ST_REM_MUL;
					end
				end
			end
			hsq_pkg::ST_REM_MUL: state_d = hsq_pkg::ST_REM;
			hsq_pkg::ST_REM: state_d = hsq_pkg::ST_SUM;
			hsq_pkg::ST_SUM: begin
				if (out_free) begin
					out_load_sum = 1'b1;
					state_d      = hsq_pkg::ST_IDLE;
				end
			end
			default: state_d = hsq_pkg::ST_IDLE;
		endcase
	end

	// control and architectural state with reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= hsq_pkg::StepReset;
			hyst_q      <= hsq_pkg::HystReset;
			tag_q       <= hsq_pkg::TagReset;
			started_q   <= 1'b0;
			remainder_q <= '0;
			div_cnt_q   <= '0;
			ev_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hsq_pkg::CfgStep: step_q <= cfg_data;
					hsq_pkg::CfgHyst: hyst_q <= cfg_data;
					hsq_pkg::CfgTag:  tag_q  <= cfg_data[hsq_pkg::TagW-1:0];
					default: ;
				endcase
			end
			if (in_accept && op == hsq_pkg::OpStop) started_q <= 1'b0;
			if (state_q == hsq_pkg::ST_DIV_MS && div_done) started_q <= 1'b1;
			if (state_q == hsq_pkg::ST_REM) begin
				remainder_q <= sample_q - mul_q[hsq_pkg::SampleW-1:0];
			end
			if ((in_accept && op == hsq_pkg::OpSample && !started_q)
				|| (state_q == hsq_pkg::ST_DIV_LV && div_done)
				|| (state_q == hsq_pkg::ST_CMP && (gt || lt))) begin
				div_cnt_q <= '0;
			end else if (!div_done) begin
				div_cnt_q <= div_cnt_q + hsq_pkg::DivCntW'(1);
			end
			if (state_q == hsq_pkg::ST_MOVE) begin
				ev_cnt_q <= '0;
			end else if (out_load_ev) begin
				ev_cnt_q <= ev_cnt_q + hsq_pkg::EvCntW'(1);
			end
			if (out_load_ev || out_load_sum) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && op == hsq_pkg::OpSample) begin
			sample_q <= sample;
			d_q      <= d_abs[hsq_pkg::SampleW-1:0];
			if (!started_q) begin
				div_rem_q <= '0;
				div_quo_q <= sample[hsq_pkg::SampleW-1] ? -abs_x : abs_x;
			end
		end
		case (state_q)
			hsq_pkg::ST_DIV_LV: begin
				if (div_done) begin
					level_q    <= lv_start;
					up_thr_q   <= lvst + st_x + hy_x;
					down_thr_q <= lvst - hy_x;
					div_rem_q  <= '0;
					div_quo_q  <= hsq_pkg::MidNumer;
				end else begin
					div_rem_q <= div_rem_nx;
					div_quo_q <= div_quo_nx;
				end
			end
			hsq_pkg::ST_DIV_MS: begin
				if (div_done) begin
					mid_scale_q <= div_quo_q[hsq_pkg::MidScaleW-1:0];
				end else begin
					div_rem_q <= div_rem_nx;
					div_quo_q <= div_quo_nx;
				end
			end
			hsq_pkg::ST_DIST: mul_q <= mul_p;
			hsq_pkg::ST_CMP: begin
				mid_q    <= dist_sat;
				dir_up_q <= gt;
				ovf_q    <= 1'b0;
				dvd_q    <= dividend;
				div_rem_q <= '0;
				div_quo_q <= dividend;
			end
			hsq_pkg::ST_DIV_N: begin
				if (div_done) begin
					// level moves the full count even when events are dropped
					level_q    <= dir_up_q ? level_q + div_quo_q[hsq_pkg::SampleW-1:0]
						: level_q - div_quo_q[hsq_pkg::SampleW-1:0];
					ev_level_q <= level_q;
					ovf_q      <= |div_quo_q[hsq_pkg::DivW-1:hsq_pkg::EvCntW];
					ev_total_q <= (|div_quo_q[hsq_pkg::DivW-1:hsq_pkg::EvCntW])
						? hsq_pkg::MaxEvCnt : div_quo_q[hsq_pkg::EvCntW-1:0];
					nst_q      <= dvd_q - {{(hsq_pkg::DivW-hsq_pkg::StepW){1'b0}}, div_rem_q};
				end else begin
					div_rem_q <= div_rem_nx;
					div_quo_q <= div_quo_nx;
				end
			end
			hsq_pkg::ST_MOVE: begin
				up_thr_q   <= dir_up_q ? up_thr_q + nst_q : up_thr_q - nst_q;
				down_thr_q <= dir_up_q ? down_thr_q + nst_q : down_thr_q - nst_q;
			end
			hsq_pkg::ST_EVENT: begin
				if (out_load_ev) ev_level_q <= ev_lv_nx;
			end
			hsq_pkg::ST_REM_MUL: mul_q <= mul_p;
			default: ;
		endcase
		if (out_load_ev) begin
			out_kind_q  <= hsq_pkg::KindEvent;
			out_level_q <= ev_lv_nx;
			out_rem_q   <= '0;
			out_mid_q   <= '0;
			out_ovf_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (out_load_sum) begin
			out_kind_q  <= hsq_pkg::KindSummary;
			out_level_q <= level_q;
			out_rem_q   <= remainder_q;
			out_mid_q   <= mid_q;
			out_ovf_q   <= ovf_q;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_kind_q;
	assign level        = out_level_q;
	assign remainder    = out_rem_q;
	assign mid_distance = out_mid_q;
	assign overflow     = out_ovf_q;
	assign event_tag    = tag_q;
	assign last         = out_last_q;

	a_last_on_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind == hsq_pkg::KindSummary)))
		else $error("last flag does not match word kind");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && op == hsq_pkg::OpStop) |=> !started_q)
		else $error("stop word did not clear started");

	a_event_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hsq_pkg::ST_EVENT) |-> (ev_cnt_q < ev_total_q))
		else $error("event count ran past its total");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(div_cnt_q <= hsq_pkg::DivCntW'(hsq_pkg::DivW)))
		else $error("divider step count out of range");

endmodule

@@ tb/tb_hysteresis_step_quantizer.sv @@
// Self-checking testbench for the hysteresis step quantizer: directed table, then random phases.
module tb_hysteresis_step_quantizer;
	import hsq_pkg::*;

	localparam int CycleLimit  = 600000;
	localparam int SettleGap   = 100;
	localparam int HoldCycles  = 400;
	localparam int TailCycles  = 120;
	localparam int DrainLimit  = 20000;
	localparam int NumRows     = 25;
	localparam int NumPhases   = 6;
	localparam int PhaseWords  = 35;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] lvl;
		logic signed [31:0] rem;
		logic [7:0]         mdist;
		logic               ovf;
		logic [7:0]         tag;
		logic               fin;
	} result_t;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t          rk;
		logic [CfgIdxW-1:0] idx;
		logic [StepW-1:0]   data;
		logic               w_op;
		logic signed [31:0] smp;
		logic               typed;
		logic signed [31:0] t_lvl;
		logic signed [31:0] t_rem;
		logic [7:0]         t_dist;
		logic               t_ovf;
	} row_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CfgIdxW-1:0]         cfg_index = CfgStep;
	logic [StepW-1:0]           cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic                       op        = OpSample;
	logic signed [SampleW-1:0]  sample    = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       kind;
	logic signed [SampleW-1:0]  level;
	logic signed [SampleW-1:0]  remainder;
	logic [DistW-1:0]           mid_distance;
	logic                       overflow;
	logic [TagW-1:0]            event_tag;
	logic                       last;

	hysteresis_step_quantizer dut (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .op, .sample,
		.out_valid, .out_stall,
		.kind, .level, .remainder, .mid_distance, .overflow, .event_tag, .last
	);

	always #5 clk = ~clk;

	// register shadows
	logic [15:0] cfg_step = StepReset;
	logic [15:0] cfg_hyst = HystReset;
	logic [7:0]  cfg_tag  = TagReset;

	// quantizer state
	logic               run_on    = 1'b0;
	logic signed [31:0] cur_level = '0;
	longint             thr_up    = 0;
	longint             thr_dn    = 0;
	logic signed [31:0] prev_rem  = '0;
	longint             scale     = 0;
	logic [7:0]         last_dist = '0;

	result_t expected_words[$];

	int mismatches   = 0;
	int words_sent   = 0;
	int words_seen   = 0;
	int events_seen  = 0;
	int overflows    = 0;
	int reg_writes   = 0;
	int send_pct     = 0;
	int recv_pct     = 0;
	int hold_req     = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int cycle_cnt    = 0;

	row_t plan [NumRows] = '{
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sd0,          1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sd100,        1'b1, 32'sd0, 32'sd100, 8'd255, 1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sd128,        1'b1, 32'sd0, 32'sd128, 8'd56,  1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sd0,          1'b1, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sd256,        1'b1, 32'sd0, 32'sd256, 8'd255, 1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sd257,        1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, -32'sd1,         1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sh7FFFFFFF,   1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sh80000000,   1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpStop,   32'sh7FFFFFFF,   1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sh80000000,   1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sh80000000,   1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_REG,  CfgTag,  16'h00FF,  OpSample, 32'sd0,          1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_REG,  CfgHyst, 16'hFFFF,  OpSample, 32'sd0,          1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sd0,          1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpStop,   32'sd0,          1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_REG,  CfgStep, 16'd0,     OpSample, 32'sd0,          1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sd5,          1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sd7,          1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpStop,   -32'sd1,         1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_REG,  CfgHyst, 16'd0,     OpSample, 32'sd0,          1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sd10,         1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		// exactly the event limit, then one past it
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sd74,         1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpSample, 32'sd9,          1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0},
		'{ROW_WORD, CfgStep, 16'd0,     OpStop,   32'sd0,          1'b0, 32'sd0, 32'sd0,   8'd0,   1'b0}
	};

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Work out the result words that one accepted input word causes.
	task automatic quantize_word(input logic w_op, input logic signed [31:0] w_smp);
		longint  s, st, hy, lv, half, d, prod, n, rem, i;
		int      dir;
		result_t r;
		s   = longint'(w_smp);
		st  = (cfg_step == 16'd0) ? 64'sd1 : longint'({48'd0, cfg_step});
		hy  = longint'({48'd0, cfg_hyst});
		dir = 0;
		n   = 0;
		if (w_op == OpStop) begin
			run_on = 1'b0;
			return;
		end
		if (!run_on) begin
			lv        = s / st;
			run_on    = 1'b1;
			cur_level = lv[31:0];
			thr_up    = (lv + 1) * st + hy;
			thr_dn    = lv * st - hy;
			scale     = 65536 / st;
			return;
		end
		// distance comes from the remainder of the previous sample
		half = st >>> 1;
		d    = longint'(prev_rem) - half;
		if (d < 0)
			d = -d;
		prod      = (d * scale) >>> DistShift;
		last_dist = (prod > 255) ? DistMax : prod[7:0];
		if (s > thr_up) begin
			n   = (s - thr_up + st - 1) / st;
			dir = 1;
		end else if (s < thr_dn) begin
			n   = (thr_dn - s + st - 1) / st;
			dir = -1;
		end
		for (i = 1; i <= n && i <= MaxEvents; i++) begin
			r = '{KindEvent, (dir > 0) ? cur_level + i[31:0] : cur_level - i[31:0],
				32'sd0, 8'd0, 1'b0, cfg_tag, 1'b0};
			expected_words.push_back(r);
		end
		if (dir > 0) begin
			cur_level = cur_level + n[31:0];
			thr_up    = thr_up + n * st;
			thr_dn    = thr_dn + n * st;
		end else if (dir < 0) begin
			cur_level = cur_level - n[31:0];
			thr_up    = thr_up - n * st;
			thr_dn    = thr_dn - n * st;
		end
		rem      = s - longint'(cur_level) * st;
		prev_rem = rem[31:0];
		r = '{KindSummary, cur_level, prev_rem, last_dist, (n > MaxEvents), cfg_tag, 1'b1};
		expected_words.push_back(r);
	endtask

	task automatic send_word(input logic w_op, input logic signed [31:0] w_smp,
			input logic typed, input result_t typed_sum);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= w_op;
		sample   <= w_smp;
		do @(posedge clk); while (in_stall);
		quantize_word(w_op, w_smp);
		words_sent++;
		if (typed) begin
			// swap in the hand-worked summary
			void'(expected_words.pop_back());
			typed_sum.tag = cfg_tag;
			expected_words.push_back(typed_sum);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [StepW-1:0] data);
		wait_drained();
		// a start word gives no result but keeps the block busy a while
		repeat (SettleGap) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			CfgStep: cfg_step = data;
			CfgHyst: cfg_hyst = data;
			CfgTag:  cfg_tag  = data[7:0];
			default: ;
		endcase
	endtask

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HoldCycles;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{kind, level, remainder, mid_distance, overflow, event_tag, last};
			if (expected_words.size() == 0) begin
				report_mismatch("word with nothing expected", 64'(got.lvl), 64'd0);
			end else begin
				want = expected_words.pop_front();
				words_seen++;
				if (want.kind == KindEvent)
					events_seen++;
				if (want.ovf)
					overflows++;
				if (got.kind != want.kind)
					report_mismatch("kind", 64'(got.kind), 64'(want.kind));
				if (got.lvl != want.lvl)
					report_mismatch("level", 64'(got.lvl), 64'(want.lvl));
				if (got.rem != want.rem)
					report_mismatch("remainder", 64'(got.rem), 64'(want.rem));
				if (got.mdist != want.mdist)
					report_mismatch("mid_distance", 64'(got.mdist), 64'(want.mdist));
				if (got.ovf != want.ovf)
					report_mismatch("overflow", 64'(got.ovf), 64'(want.ovf));
				if (got.tag != want.tag)
					report_mismatch("event_tag", 64'(got.tag), 64'(want.tag));
				if (got.fin != want.fin)
					report_mismatch("last", 64'(got.fin), 64'(want.fin));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CycleLimit) begin
			$display("Timeout after %0d cycles, %0d words still expected", cycle_cnt,
				expected_words.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		result_t     typed_sum;
		longint      last_smp, delta, span, nxt;
		int          roll, waited;
		logic [15:0] p_step, p_hyst, p_tag;
		send_pct = 22;
		recv_pct <= 49;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NumRows; r++) begin
			if (plan[r].rk == ROW_REG) begin
				write_reg(plan[r].idx, plan[r].data);
			end else begin
				typed_sum = '{KindSummary, plan[r].t_lvl, plan[r].t_rem, plan[r].t_dist,
					plan[r].t_ovf, 8'd0, 1'b1};
				send_word(plan[r].w_op, plan[r].smp, plan[r].typed, typed_sum);
			end
		end

		last_smp = 0;
		for (int ph = 0; ph < NumPhases; ph++) begin
			case (ph)
				0: begin p_step = 16'd256;   p_hyst = 16'd0;     p_tag = 16'h005A; end
				1: begin p_step = 16'd1;     p_hyst = 16'hFFFF;  p_tag = 16'h00FF; end
				2: begin p_step = 16'hFFFF;  p_hyst = 16'd0;     p_tag = 16'h0000; end
				3: begin p_step = 16'd0;     p_hyst = 16'd3;     p_tag = 16'hA581; end
				4: begin p_step = 16'd1000;  p_hyst = 16'd300;   p_tag = 16'h003C; end
				default: begin
					p_step = 16'($urandom_range(65535, 1));
					p_hyst = 16'($urandom_range(65535, 0));
					p_tag  = 16'($urandom);
				end
			endcase
			if (ph == 2) begin
				send_pct = 49;
				recv_pct <= 22;
			end else if (ph == 4) begin
				send_pct = 0;
				recv_pct <= 0;
			end
			write_reg(CfgStep, p_step);
			write_reg(CfgHyst, p_hyst);
			write_reg(CfgTag, p_tag);
			span = 3 * ((p_step == 16'd0) ? 1 : longint'({48'd0, p_step})) +
				longint'({48'd0, p_hyst}) + 2;
			for (int k = 0; k < PhaseWords; k++) begin
				if (ph == 1 && k == 10)
					hold_req <= hold_req + 1;
				if (ph == 3 && k == 17)
					wait_drained();
				roll = $urandom_range(99);
				if (roll < 6) begin
					send_word(OpStop, 32'($urandom), 1'b0, '0);
				end else if (roll < 14) begin
					nxt = longint'(signed'(32'($urandom)));
					last_smp = nxt;
					send_word(OpSample, nxt[31:0], 1'b0, '0);
				end else begin
					if (roll < 22)
						// jump 40 to 80 steps, far enough to run into the event limit unless the hysteresis is wide
						delta = longint'($urandom_range(80, 40)) *
							((p_step == 16'd0) ? 1 : longint'({48'd0, p_step}));
					else
						delta = longint'($urandom_range(32'(2 * span))) - span;
					if ($urandom_range(1) == 1 && roll < 22)
						delta = -delta;
					nxt = last_smp + delta;
					if (nxt > 64'sd2147483647)
						nxt = 64'sd2147483647;
					if (nxt < -64'sd2147483648)
						nxt = -64'sd2147483648;
					last_smp = nxt;
					send_word(OpSample, nxt[31:0], 1'b0, '0);
				end
			end
		end

		in_valid <= 1'b0;
		waited = 0;
		while (expected_words.size() != 0 && waited < DrainLimit) begin
			@(posedge clk);
			waited++;
		end
		if (expected_words.size() != 0)
			report_mismatch("words never delivered", 64'd0, 64'(expected_words.size()));
		repeat (TailCycles) @(posedge clk);

		$display("Sent %0d input words over %0d register writes; checked %0d result words",
			words_sent, reg_writes, words_seen);
		$display("  (%0d level changes, %0d summaries with dropped events), %0d mismatches",
			events_seen, overflows, mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
